// ===== design/kvi_pkg.sv =====
`default_nettype none
package kvi_pkg;

  localparam int MAX_KEYS_DEF  = 256;
  localparam int FRAC_BITS_DEF = 16;

  localparam int COUNT_W  = 9;
  localparam int INDEX_W  = 8;
  localparam int WORD_W   = 32;
  localparam int REGION_W = 2;
  // wide enough for any table index or count in the parameter range
  localparam int WIDE_W   = 13;

  localparam int S_DATA_W = 168;
  localparam int M_DATA_W = 96;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [REGION_W-1:0] REGION_INTERP = 2'd0;
  localparam logic [REGION_W-1:0] REGION_FIRST  = 2'd1;
  localparam logic [REGION_W-1:0] REGION_LAST   = 2'd2;

endpackage
`default_nettype wire

// ===== design/keyframe_vector_interpolator.sv =====
`default_nettype none
// load item: accepted only while idle, written to the key memories at once
// query item: clamped to the first key or to the last key when it lies outside them,
//   otherwise found by binary search and interpolated; each read of the key memories
//   waits on a registered read, the divider makes one quotient bit per cycle, and
//   the three components take turns on the shared multiplier
// one query at a time; the next item is taken while the result waits at the output
// rst clears control state and sets key_count to 1; the key memories are not cleared
module keyframe_vector_interpolator #(
  parameter int MAX_KEYS  = kvi_pkg::MAX_KEYS_DEF,
  parameter int FRAC_BITS = kvi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [kvi_pkg::COUNT_W-1:0]   cfg_data,   // key_count
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // key_index, key_time, key_x, key_y, key_z, query_time
  input  wire logic [kvi_pkg::S_DATA_W-1:0]  s_tdata,
  input  wire logic                          s_tuser,    // command
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [kvi_pkg::M_DATA_W-1:0]       m_tdata,    // out_x, out_y, out_z
  output logic [kvi_pkg::REGION_W-1:0]       m_tuser     // region
);
  import kvi_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam int PW = WORD_W + 1 + FRAC_BITS + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_WAIT, S_CHK0, S_CHK1, S_SRCH, S_GETLO, S_GETHI, S_DIV, S_MUL, S_ADD, S_DONE
  } state_t;

  state_t state, ret;

  logic [COUNT_W-1:0] key_count;
  logic [WORD_W-1:0] time_mem [MAX_KEYS];
  logic [WORD_W-1:0] x_mem [MAX_KEYS];
  logic [WORD_W-1:0] y_mem [MAX_KEYS];
  logic [WORD_W-1:0] z_mem [MAX_KEYS];
  logic [WORD_W-1:0] rd_t, rd_x, rd_y, rd_z;
  logic [AW-1:0] rd_addr, lo, hi, mid;
  logic [WORD_W-1:0] t, t0;
  logic [WORD_W-1:0] v_lo [3];
  logic [WORD_W-1:0] v_hi [3];
  logic [WORD_W-1:0] res [3];
  logic [REGION_W-1:0] res_region;
  logic [WORD_W:0] rem;
  logic [WORD_W-1:0] den;
  logic [FRAC_BITS-1:0] frac;
  logic [CNT_W-1:0] cnt;
  logic [1:0] comp;
  logic signed [PW-1:0] prod;

  // unpacked input fields
  logic [INDEX_W-1:0] key_index;
  logic [WORD_W-1:0] key_time, key_x, key_y, key_z, query_time;
  assign key_index  = s_tdata[7:0];
  assign key_time   = s_tdata[39:8];
  assign key_x      = s_tdata[71:40];
  assign key_y      = s_tdata[103:72];
  assign key_z      = s_tdata[135:104];
  assign query_time = s_tdata[167:136];

  logic [WIDE_W-1:0] n_c, idx_w;
  logic [AW-1:0] last_c, waddr;
  logic wr_ok, mem_we;
  always_comb begin
    n_c = (key_count == '0) ? WIDE_W'(1) : WIDE_W'(key_count);
    if (n_c > WIDE_W'(MAX_KEYS)) n_c = WIDE_W'(MAX_KEYS);
    last_c = AW'(n_c - WIDE_W'(1));
    idx_w = WIDE_W'(key_index);
    wr_ok = idx_w < WIDE_W'(MAX_KEYS);
    waddr = idx_w[AW-1:0];
  end

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign mem_we = s_tvalid && s_tready && (s_tuser == CMD_LOAD) && wr_ok;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem[waddr] <= key_time;
      x_mem[waddr]    <= key_x;
      y_mem[waddr]    <= key_y;
      z_mem[waddr]    <= key_z;
    end
    rd_t <= time_mem[rd_addr];
    rd_x <= x_mem[rd_addr];
    rd_y <= y_mem[rd_addr];
    rd_z <= z_mem[rd_addr];
  end

  // search window: set to the whole table after the last-key check, then narrowed from the time just read at mid
  logic [AW-1:0] lo_n, hi_n, gap_n;
  always_comb begin
    lo_n = lo;
    hi_n = hi;
    if (state == S_CHK1) begin
      lo_n = '0;
      hi_n = last_c;
    end else if (rd_t <= t) begin
      lo_n = mid;
    end else begin
      hi_n = mid;
    end
    gap_n = hi_n - lo_n;
  end

  // one restoring division step
  logic [WORD_W:0] rem_sh;
  logic rem_ge;
  assign rem_sh = {rem[WORD_W-1:0], 1'b0};
  assign rem_ge = rem_sh >= {1'b0, den};

  logic signed [WORD_W:0] diff;
  assign diff = $signed({v_hi[comp][WORD_W-1], v_hi[comp]})
              - $signed({v_lo[comp][WORD_W-1], v_lo[comp]});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      key_count <= COUNT_W'(1);
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) key_count <= cfg_data;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tuser == CMD_QUERY) begin
            t <= query_time;
            rd_addr <= '0;
            ret <= S_CHK0;
            state <= S_WAIT;
          end
        end
        S_WAIT: state <= ret;
        S_CHK0: begin
          if (t <= rd_t) begin
            res[0] <= rd_x;
            res[1] <= rd_y;
            res[2] <= rd_z;
            res_region <= REGION_FIRST;
            state <= S_DONE;
          end else begin
            rd_addr <= last_c;
            ret <= S_CHK1;
            state <= S_WAIT;
          end
        end
        S_CHK1, S_SRCH: begin
          if (state == S_CHK1 && t >= rd_t) begin
            res[0] <= rd_x;
            res[1] <= rd_y;
            res[2] <= rd_z;
            res_region <= REGION_LAST;
            state <= S_DONE;
          end else begin
            lo <= lo_n;
            hi <= hi_n;
            state <= S_WAIT;
            if (gap_n > AW'(1)) begin
              mid <= lo_n + (gap_n >> 1);
              rd_addr <= lo_n + (gap_n >> 1);
              ret <= S_SRCH;
            end else begin
              rd_addr <= lo_n;
              ret <= S_GETLO;
            end
          end
        end
        S_GETLO: begin
          t0 <= rd_t;
          v_lo[0] <= rd_x;
          v_lo[1] <= rd_y;
          v_lo[2] <= rd_z;
          rd_addr <= hi;
          ret <= S_GETHI;
          state <= S_WAIT;
        end
        S_GETHI: begin
          v_hi[0] <= rd_x;
          v_hi[1] <= rd_y;
          v_hi[2] <= rd_z;
          rem <= {1'b0, t - t0};
          den <= rd_t - t0;
          cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= rem_ge ? rem_sh - {1'b0, den} : rem_sh;
          frac <= {frac[FRAC_BITS-2:0], rem_ge};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(FRAC_BITS - 1)) begin
            comp <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= PW'(diff) * $signed(PW'({1'b0, frac}));
          state <= S_ADD;
        end
        S_ADD: begin
          // arithmetic shift gives the floor of the scaled product
          res[comp] <= v_lo[comp] + prod[FRAC_BITS +: WORD_W];
          if (comp == 2'd2) begin
            res_region <= REGION_INTERP;
            state <= S_DONE;
          end else begin
            comp <= comp + 2'd1;
            state <= S_MUL;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {res[2], res[1], res[0]};
            m_tuser <= res_region;
            m_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> den != '0)
    else $error("divisor zero in fraction division");

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    state == S_SRCH |-> (lo < mid) && (mid < hi))
    else $error("search probe outside window");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_QUERY |=> !s_tready)
    else $error("ready after query accept");

  a_region_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == REGION_INTERP) || (m_tuser == REGION_FIRST)
                 || (m_tuser == REGION_LAST))
    else $error("bad region code");

endmodule
`default_nettype wire

// ===== tb/tb_keyframe_vector_interpolator.sv =====
module tb_keyframe_vector_interpolator;
  import kvi_pkg::*;

  localparam int NKEYS     = 256;
  localparam int FB        = 16;
  localparam int SETTLE    = 80;
  localparam int HOLD_LEN  = 600;
  localparam int DOG_LIMIT = 4000;

  typedef struct packed {
    logic                      cmd;
    logic [INDEX_W-1:0]        idx;
    logic [WORD_W-1:0]         ktime;
    logic [WORD_W-1:0]         kx;
    logic [WORD_W-1:0]         ky;
    logic [WORD_W-1:0]         kz;
    logic [WORD_W-1:0]         qtime;
  } key_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]   vx;
    logic [WORD_W-1:0]   vy;
    logic [WORD_W-1:0]   vz;
    logic [REGION_W-1:0] region;
  } vec_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [REGION_W-1:0] m_tuser;

  keyframe_vector_interpolator u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [WORD_W-1:0]  time_mem [NKEYS];
  logic [WORD_W-1:0]  x_mem [NKEYS];
  logic [WORD_W-1:0]  y_mem [NKEYS];
  logic [WORD_W-1:0]  z_mem [NKEYS];
  logic [COUNT_W-1:0] key_count = COUNT_W'(1);

  // shadow of the key times as the generator left them
  logic [WORD_W-1:0]  gen_time [NKEYS];
  int                 gen_count = 1;

  key_item_t pend_q [$];
  vec_out_t  vec_q [$];
  int queued_cnt = 0;
  int sent_cnt = 0;
  int err_cnt = 0;
  int snd_idle = 0;
  int rcv_stall = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int dog = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] a_bits,
                                            input logic [WORD_W-1:0] b_bits,
                                            input longint unsigned f);
    longint a, b, d, q;
    longint unsigned p;
    a = longint'(signed'(a_bits));
    b = longint'(signed'(b_bits));
    d = b - a;
    if (d >= 0) begin
      p = longint'(d) * f;
      q = longint'(p >> FB);
    end else begin
      p = longint'(-d) * f;
      // negative steps round toward minus infinity
      q = -longint'((p + 64'hFFFF) >> FB);
    end
    return WORD_W'(a + q);
  endfunction

  function automatic vec_out_t sample_at(input logic [WORD_W-1:0] t);
    int n, lo, hi, mid;
    longint unsigned f;
    vec_out_t r;
    n = (key_count == 0) ? 1 : (key_count > NKEYS) ? NKEYS : int'(key_count);
    if (t <= time_mem[0]) begin
      r = '{x_mem[0], y_mem[0], z_mem[0], REGION_FIRST};
    end else if (t >= time_mem[n-1]) begin
      r = '{x_mem[n-1], y_mem[n-1], z_mem[n-1], REGION_LAST};
    end else begin
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
        mid = lo + (hi - lo) / 2;
        if (time_mem[mid] <= t) lo = mid;
        else hi = mid;
      end
      f = (longint'(t - time_mem[lo]) << FB) / longint'(time_mem[hi] - time_mem[lo]);
      r.vx = mix(x_mem[lo], x_mem[hi], f);
      r.vy = mix(y_mem[lo], y_mem[hi], f);
      r.vz = mix(z_mem[lo], z_mem[hi], f);
      r.region = REGION_INTERP;
    end
    return r;
  endfunction

  // driver
  key_item_t cur;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (cur.cmd == CMD_LOAD) begin
          time_mem[cur.idx] = cur.ktime;
          x_mem[cur.idx] = cur.kx;
          y_mem[cur.idx] = cur.ky;
          z_mem[cur.idx] = cur.kz;
        end else begin
          vec_q.push_back(sample_at(cur.qtime));
        end
        sent_cnt++;
      end
      if (!s_tvalid || s_tready) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
          cur = pend_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= cur.cmd;
          s_tdata <= {cur.qtime, cur.kz, cur.ky, cur.kx, cur.ktime, cur.idx};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold, counted here
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    vec_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (vec_q.size() == 0) begin
        report($sformatf("unexpected result %h region %0d", m_tdata, m_tuser));
      end else begin
        want = vec_q.pop_front();
        if (m_tdata[31:0] !== want.vx)
          report($sformatf("out_x %h, want %h", m_tdata[31:0], want.vx));
        if (m_tdata[63:32] !== want.vy)
          report($sformatf("out_y %h, want %h", m_tdata[63:32], want.vy));
        if (m_tdata[95:64] !== want.vz)
          report($sformatf("out_z %h, want %h", m_tdata[95:64], want.vz));
        if (m_tuser !== want.region)
          report($sformatf("region %0d, want %0d", m_tuser, want.region));
      end
    end
    m_tready <= !rst && hold_left == 0 && $urandom_range(99) >= rcv_stall;
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      dog <= 0;
    else
      dog <= dog + 1;
    if (dog >= DOG_LIMIT) begin
      $display("tb_keyframe_vector_interpolator NOT OK");
      $finish;
    end
  end

  task automatic push_item(input key_item_t it);
    if (it.cmd == CMD_LOAD) gen_time[it.idx] = it.ktime;
    pend_q.push_back(it);
    queued_cnt++;
  endtask

  task automatic load_key(input int k, input logic [31:0] t, input logic [31:0] vx,
                          input logic [31:0] vy, input logic [31:0] vz);
    push_item('{CMD_LOAD, 8'(k), t, vx, vy, vz, $urandom()});
  endtask

  task automatic query(input logic [31:0] t);
    push_item('{CMD_QUERY, 8'($urandom()), $urandom(), $urandom(), $urandom(),
                $urandom(), t});
  endtask

  task automatic drain();
    while (sent_cnt < queued_cnt || vec_q.size() > 0) @(posedge clk);
  endtask

  // key_count writes only with the block idle
  task automatic set_count(input int v);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= COUNT_W'(v);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    key_count = COUNT_W'(v);
    cfg_valid <= 1'b0;
    gen_count = (v == 0) ? 1 : (v > NKEYS) ? NKEYS : v;
  endtask

  task automatic rand_item();
    int k, j;
    logic [31:0] lo_t, hi_t;
    if ($urandom_range(99) < 25) begin
      k = $urandom_range(99) < 85 ? $urandom_range(gen_count - 1) : $urandom_range(NKEYS - 1);
      lo_t = (k == 0) ? 32'd0 : gen_time[k-1];
      hi_t = (k == NKEYS - 1) ? 32'hFFFFFFFF : gen_time[k+1];
      // mostly keep the table sorted, sometimes write anything
      if ($urandom_range(99) < 80 && hi_t > lo_t)
        load_key(k, lo_t + $urandom_range(hi_t - lo_t), $urandom(), $urandom(), $urandom());
      else
        load_key(k, $urandom(), $urandom(), $urandom(), $urandom());
    end else begin
      j = $urandom_range(99);
      if (j < 70 && gen_count > 1) begin
        k = $urandom_range(gen_count - 2);
        lo_t = gen_time[k];
        hi_t = gen_time[k+1];
        query(hi_t > lo_t ? lo_t + $urandom_range(hi_t - lo_t) : $urandom());
      end else if (j < 82) begin
        query(gen_time[$urandom_range(gen_count - 1)]);
      end else begin
        query($urandom());
      end
    end
  endtask

  task automatic rand_phase(input int items, input int idle_s, input int idle_r);
    int counts [6] = '{2, 3, 16, 256, 0, 511};
    snd_idle = idle_s;
    rcv_stall = idle_r;
    for (int b = 0; b < 4; b++) begin
      set_count($urandom_range(3) == 0 ? counts[$urandom_range(5)] : $urandom_range(1, 256));
      for (int i = 0; i < items / 4; i++) rand_item();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // fill the whole table with ascending times before anything reads it
    load_key(0, 32'h0, 32'h80000000, 32'h7FFFFFFF, 32'h0);
    load_key(1, 32'h10000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    for (int k = 2; k < NKEYS - 1; k++)
      load_key(k, (k << 24) + $urandom_range(32'hFFFFFF), $urandom(), $urandom(), $urandom());
    load_key(NKEYS - 1, 32'hFFFFFFFF, $urandom(), $urandom(), $urandom());

    // single key: at the first time and past it
    set_count(1);
    query(32'h0);
    query(32'hFFFFFFFF);
    query(32'h8000);
    // two keys with full-scale swings both ways
    set_count(2);
    query(32'h1);
    query(32'h8000);
    query(32'hFFFF);
    query(32'h10000);
    set_count(256);
    query(32'h0);
    query(32'hFFFFFFFF);
    query(32'hFFFFFFFE);
    query(gen_time[128]);
    query(gen_time[128] + 1);
    query(gen_time[200] - 1);
    // zero acts as one key, oversize acts as the full table
    set_count(0);
    query(32'h7);
    set_count(511);
    query(32'hFFFFFFFF);
    query(gen_time[254] + 1);
    // load to index 255 with extremes, then query at the last time and just after key 254
    load_key(NKEYS - 1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h1);
    query(32'hFFFFFFFF);
    query(gen_time[254] + 32'h100);

    rand_phase(300, 0, 0);
    rand_phase(300, 84, 0);
    rand_phase(300, 0, 84);

    // receiver holds while the sender keeps offering items
    set_count(256);
    snd_idle = 0;
    rcv_stall = 0;
    hold_req++;
    for (int i = 0; i < 60; i++) rand_item();
    drain();
    // sender pauses until everything has come back
    for (int i = 0; i < 20; i++) rand_item();
    drain();

    rand_phase(300, 31, 31);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (err_cnt == 0)
      $display("tb_keyframe_vector_interpolator OK");
    else
      $display("tb_keyframe_vector_interpolator NOT OK");
    $finish;
  end

endmodule
